>>> sv/lfg_pkg.sv
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared types and constants of the lag-273/607 additive uniform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfg_pkg;

  localparam int RING_DEPTH = 607;
  localparam int FRAC_BITS  = 24;
  localparam int SHORT_LAG  = 273;
  localparam int LAG_OFFSET = RING_DEPTH - SHORT_LAG;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int COUNT_W    = 7;
  localparam int SEED_W     = 15;
  localparam int MAX_DRAW   = 64;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COUNT_W-1:0] count;
    logic [SEED_W-1:0]  seed_value;
  } lfg_in_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] value;
    logic                 last;
    logic                 not_seeded;
  } lfg_out_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [PTR_W-1:0]     idx;
    logic [FRAC_BITS-1:0] word;
  } lfg_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SEED
  } ctrl_state_t;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_INIT,
    GS_MUL,
    GS_MOD,
    GS_MULC,
    GS_MODC,
    GS_BIT
  } gen_state_t;

endpackage

`default_nettype wire

>>> sv/lfg_ring_ram.sv
// ----------------------------------------------------------------------------
// lfg_ring_ram
// Lag ring storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_ring_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lfg_pkg::PTR_W-1:0]     waddr,
  input  logic [lfg_pkg::FRAC_BITS-1:0] wdata,
  input  logic [lfg_pkg::PTR_W-1:0]     raddr_a,
  input  logic [lfg_pkg::PTR_W-1:0]     raddr_b,
  output logic [lfg_pkg::FRAC_BITS-1:0] rdata_a,
  output logic [lfg_pkg::FRAC_BITS-1:0] rdata_b
);
  import lfg_pkg::*;

  logic [FRAC_BITS-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> sv/lfg_seed_gen.sv
// ----------------------------------------------------------------------------
// lfg_seed_gen
// Seed bit generator: combined mod-179 / mod-169 sequences, one bit per pass
// through the MUL, MOD, MULC, MODC and BIT states, emits one ring word every 24 bits, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_seed_gen (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lfg_pkg::SEED_W-1:0] seed,
  output lfg_pkg::lfg_word_t         word_o
);
  import lfg_pkg::*;

  localparam int VAL_W        = 8;
  localparam int PROD_W       = 16;
  localparam int LIN_W        = 14;
  localparam int BIT_W        = $clog2(FRAC_BITS);
  localparam int PRIME_A      = 179;
  localparam int MOD_D        = 169;
  localparam int DIV_IJ       = 177;
  localparam int MOD_C        = 178;
  localparam int LCG_MUL      = 53;
  localparam int SEED_MOD     = 31328;
  localparam int DEFAULT_SEED = 1802;
  localparam int KL_SEED      = 9373;
  localparam int C_INIT       = (KL_SEED / MOD_D) % MOD_C + 1;
  localparam int D_INIT       = KL_SEED % MOD_D;
  localparam int TEST_BIT     = $clog2(32);
  localparam int LOW_W        = TEST_BIT + 1;

  typedef struct packed {
    logic [VAL_W-1:0] quo;
    logic [VAL_W-1:0] rem;
  } divmod_t;

  function automatic logic [VAL_W-1:0] mod_a(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] r;
    r = x;
    for (int k = VAL_W - 1; k >= 0; k--) begin
      if (r >= (PROD_W'(PRIME_A) << k)) begin
        r = r - (PROD_W'(PRIME_A) << k);
      end
    end
    return r[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] mod_d(input logic [LIN_W-1:0] x);
    logic [LIN_W-1:0] r;
    r = x;
    for (int k = 5; k >= 0; k--) begin
      if (r >= (LIN_W'(MOD_D) << k)) begin
        r = r - (LIN_W'(MOD_D) << k);
      end
    end
    return r[VAL_W-1:0];
  endfunction

  function automatic divmod_t div_ij(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] r;
    divmod_t           res;
    r   = x;
    res = '0;
    for (int k = VAL_W - 1; k >= 0; k--) begin
      if (r >= (SEED_W'(DIV_IJ) << k)) begin
        r           = r - (SEED_W'(DIV_IJ) << k);
        res.quo[k]  = 1'b1;
      end
    end
    res.rem = r[VAL_W-1:0];
    return res;
  endfunction

  gen_state_t           state_r, state_nxt;
  logic [SEED_W-1:0]    ij_r, ij_nxt;
  logic [VAL_W-1:0]     a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [VAL_W-1:0]     t_r, t_nxt, m_r, m_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [LIN_W-1:0]     lin_r, lin_nxt;
  logic [FRAC_BITS-1:0] acc_r, acc_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [PTR_W-1:0]     ent_r, ent_nxt;
  logic [2*LOW_W-1:0]   dm_prod;
  logic                 gen_bit;
  logic                 word_done;
  logic                 ring_done;
  divmod_t              ij_dm;

  assign dm_prod   = {{LOW_W{1'b0}}, d_r[LOW_W-1:0]} * {{LOW_W{1'b0}}, m_r[LOW_W-1:0]};
  assign gen_bit   = dm_prod[TEST_BIT];
  assign word_done = (bit_r == BIT_W'(FRAC_BITS - 1));
  assign ring_done = (ent_r == PTR_W'(RING_DEPTH - 1));
  assign ij_dm     = div_ij(ij_r);

  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      GS_IDLE: if (start) state_nxt = GS_INIT;
      GS_INIT: state_nxt = GS_MUL;
      GS_MUL:  state_nxt = GS_MOD;
      GS_MOD:  state_nxt = GS_MULC;
      GS_MULC: state_nxt = GS_MODC;
      GS_MODC: state_nxt = GS_BIT;
      GS_BIT: begin
        if (word_done && ring_done) begin
          state_nxt = GS_IDLE;
        end else begin
          state_nxt = GS_MUL;
        end
      end
      default: state_nxt = GS_IDLE;
    endcase
  end

  always_comb begin : datapath
    ij_nxt   = ij_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    t_nxt    = t_r;
    m_nxt    = m_r;
    prod_nxt = prod_r;
    lin_nxt  = lin_r;
    acc_nxt  = acc_r;
    bit_nxt  = bit_r;
    ent_nxt  = ent_r;
    case (state_r)
      GS_IDLE: begin
        if (start) begin
          if (seed == '0) begin
            ij_nxt = SEED_W'(DEFAULT_SEED);
          end else if (seed >= SEED_W'(SEED_MOD)) begin
            ij_nxt = seed - SEED_W'(SEED_MOD);
          end else begin
            ij_nxt = seed;
          end
          bit_nxt = '0;
          ent_nxt = '0;
        end
      end
      GS_INIT: begin
        a_nxt = ij_dm.quo + VAL_W'(2);
        b_nxt = ij_dm.rem + VAL_W'(2);
        c_nxt = VAL_W'(C_INIT);
        d_nxt = VAL_W'(D_INIT);
      end
      GS_MUL: begin
        prod_nxt = {{(PROD_W-VAL_W){1'b0}}, a_r} * {{(PROD_W-VAL_W){1'b0}}, b_r};
        lin_nxt  = {{(LIN_W-VAL_W){1'b0}}, d_r} * LIN_W'(LCG_MUL) + LIN_W'(1);
      end
      GS_MOD: begin
        t_nxt = mod_a(prod_r);
        d_nxt = mod_d(lin_r);
      end
      GS_MULC: begin
        prod_nxt = {{(PROD_W-VAL_W){1'b0}}, t_r} * {{(PROD_W-VAL_W){1'b0}}, c_r};
      end
      GS_MODC: begin
        m_nxt = mod_a(prod_r);
      end
      GS_BIT: begin
        acc_nxt = {acc_r[FRAC_BITS-2:0], gen_bit};
        a_nxt   = b_r;
        b_nxt   = c_r;
        c_nxt   = m_r;
        if (word_done) begin
          bit_nxt = '0;
          ent_nxt = ent_r + PTR_W'(1);
        end else begin
          bit_nxt = bit_r + BIT_W'(1);
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_comb begin : outputs
    word_o.valid = (state_r == GS_BIT) && word_done;
    word_o.last  = ring_done;
    word_o.idx   = ent_r;
    word_o.word  = {acc_r[FRAC_BITS-2:0], gen_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GS_IDLE;
      bit_r   <= '0;
      ent_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      ent_r   <= ent_nxt;
    end
    ij_r   <= ij_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    t_r    <= t_nxt;
    m_r    <= m_nxt;
    prod_r <= prod_nxt;
    lin_r  <= lin_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

`default_nettype wire

>>> sv/lagged_fibonacci_uniform_rng.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_uniform_rng
// Additive lagged Fibonacci uniform generator, lags 273 and 607, 24-bit
// fractions held in a 607-entry ring memory.
// ----------------------------------------------------------------------------
// Draw of n values: each passes the draw state, the ring memory's registered
// read port and the output register, one per cycle; busy holds until the
// read-modify-write loop writes back the last sum. Seed: returns no values.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset clears pointer and seeded flag; ring contents are undefined until the
// first seed, and draws before it return zero with not_seeded set.
`default_nettype none

module lagged_fibonacci_uniform_rng (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lfg_pkg::lfg_in_t  in_req,
  output logic              out_strobe,
  output lfg_pkg::lfg_out_t out_res
);
  import lfg_pkg::*;

  ctrl_state_t          state_r, state_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic                 seeded_r, seeded_nxt;
  logic [COUNT_W-1:0]   remain_r, remain_nxt;
  logic                 rd_valid_r, rd_valid_nxt;
  logic [PTR_W-1:0]     wr_addr_r, wr_addr_nxt;
  logic                 last_r, last_nxt;
  logic                 ns_r, ns_nxt;
  lfg_out_t             out_r, out_nxt;
  logic                 out_strobe_r, out_strobe_nxt;

  logic                 in_accept;
  logic                 issue;
  logic                 gen_start;
  lfg_word_t            gen_word;
  logic [PTR_W:0]       q_sum;
  logic [PTR_W-1:0]     q_addr;
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [FRAC_BITS-1:0] ram_wdata;
  logic [FRAC_BITS-1:0] rdata_a;
  logic [FRAC_BITS-1:0] rdata_b;
  logic [FRAC_BITS-1:0] lag_sum;

  assign busy      = (state_r != ST_IDLE) || rd_valid_r;
  assign in_accept = start && !busy;
  assign gen_start = in_accept && (in_req.cmd == CMD_SEED);
  assign issue     = (state_r == ST_DRAW);
  assign q_sum     = {1'b0, ptr_r} + (PTR_W+1)'(LAG_OFFSET);
  assign q_addr    = (q_sum >= (PTR_W+1)'(RING_DEPTH)) ?
                     PTR_W'(q_sum - (PTR_W+1)'(RING_DEPTH)) : q_sum[PTR_W-1:0];
  assign lag_sum   = rdata_a + rdata_b;

  lfg_seed_gen u_seed_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gen_start),
    .seed   (in_req.seed_value),
    .word_o (gen_word)
  );

  lfg_ring_ram u_ring_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ptr_r),
    .raddr_b (q_addr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_req.cmd == CMD_SEED) begin
            state_nxt = ST_SEED;
          end else if (in_req.count != '0) begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_DRAW: if (remain_r == COUNT_W'(1)) state_nxt = ST_IDLE;
      ST_SEED: if (gen_word.valid && gen_word.last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    remain_nxt = remain_r;
    ptr_nxt    = ptr_r;
    seeded_nxt = seeded_r;
    if (in_accept && (in_req.cmd == CMD_DRAW)) begin
      remain_nxt = (in_req.count > COUNT_W'(MAX_DRAW)) ? COUNT_W'(MAX_DRAW) : in_req.count;
    end else if (issue) begin
      remain_nxt = remain_r - COUNT_W'(1);
    end
    // advance the pointer only once the ring holds seeded data
    if (issue && seeded_r) begin
      ptr_nxt = (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);
    end
    if ((state_r == ST_SEED) && gen_word.valid && gen_word.last) begin
      ptr_nxt    = '0;
      seeded_nxt = 1'b1;
    end

    rd_valid_nxt = issue;
    wr_addr_nxt  = ptr_r;
    last_nxt     = (remain_r == COUNT_W'(1));
    ns_nxt       = !seeded_r;

    out_strobe_nxt     = rd_valid_r;
    out_nxt.value      = ns_r ? '0 : rdata_a;
    out_nxt.last       = last_r;
    out_nxt.not_seeded = ns_r;

    if (state_r == ST_SEED) begin
      ram_we    = gen_word.valid;
      ram_waddr = gen_word.idx;
      ram_wdata = gen_word.word;
    end else begin
      ram_we    = rd_valid_r && !ns_r;
      ram_waddr = wr_addr_r;
      ram_wdata = lag_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ptr_r        <= '0;
      seeded_r     <= 1'b0;
      remain_r     <= '0;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      seeded_r     <= seeded_nxt;
      remain_r     <= remain_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    wr_addr_r <= wr_addr_nxt;
    last_r    <= last_nxt;
    ns_r      <= ns_nxt;
    out_r     <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid_r && !ns_r && (state_r == ST_DRAW)) |->
      ((wr_addr_r != q_addr) && (wr_addr_r != ptr_r)))
    else $error("ring write collides with a read in flight");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r < PTR_W'(RING_DEPTH))
    else $error("read pointer out of ring range");

  a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.not_seeded) |-> (out_r.value == '0))
    else $error("unseeded result carries nonzero value");

  a_seed_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED) |-> !rd_valid_r)
    else $error("draw write pending during seed fill");

  a_run_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.last) |=> !out_strobe_r)
    else $error("result follows the last result of a run");

endmodule

`default_nettype wire
